FILE: rtl/dconv_pkg.sv
package dconv_pkg;

  // sizing of the stores
  localparam int MAX_SEQ    = 256;
  localparam int MAX_IN_CH  = 32;
  localparam int MAX_OUT_CH = 32;
  localparam int MAX_TAPS   = 8;

  localparam int W_DEPTH = MAX_OUT_CH * MAX_TAPS * MAX_IN_CH;
  localparam int S_DEPTH = MAX_SEQ * MAX_IN_CH;
  localparam int B_DEPTH = MAX_OUT_CH;

  localparam int W_AW = $clog2(W_DEPTH);
  localparam int S_AW = $clog2(S_DEPTH);
  localparam int B_AW = $clog2(B_DEPTH);

  // counter and clamped-register widths
  localparam int SEQ_W = $clog2(MAX_SEQ);
  localparam int LEN_W = $clog2(MAX_SEQ + 1);
  localparam int TAP_W = $clog2(MAX_TAPS + 1);
  localparam int CH_W  = $clog2(MAX_IN_CH + 1);
  localparam int OCH_W = $clog2(MAX_OUT_CH + 1);

  // item field widths
  localparam int OP_W   = 2;
  localparam int IDX_W  = 13;
  localparam int VAL_W  = 32;
  localparam int OT_W   = 8;
  localparam int OC_W   = 5;
  localparam int ACC_W  = 48;
  localparam int SMP_W  = 16;
  localparam int BIAS_W = 32;
  localparam int PROD_W = 2 * SMP_W;

  // configuration register widths
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int STR_W     = 5;
  localparam int PAD_W     = 4;
  localparam int DIL_W     = 5;
  localparam int KLEN_W    = 4;
  localparam int INCH_W    = 6;
  localparam int OUTCH_W   = 6;
  localparam int SLEN_W    = 9;

  // datapath widths for address and row arithmetic
  localparam int OTS_W  = OT_W + STR_W;
  localparam int SPAN_W = 9;
  localparam int TOT_W  = 10;
  localparam int ROW_W  = OTS_W + 1;
  localparam int OCK_W  = OC_W + TAP_W;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_LOAD_SAMPLE = 2'd2,
    OP_COMPUTE     = 2'd3
  } dconv_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRIDE       = 3'd0,
    REG_PAD_FRONT    = 3'd1,
    REG_PAD_BACK     = 3'd2,
    REG_DILATION     = 3'd3,
    REG_KERNEL_LEN   = 3'd4,
    REG_IN_CHANNELS  = 3'd5,
    REG_OUT_CHANNELS = 3'd6,
    REG_SEQ_LEN      = 3'd7
  } dconv_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_BIAS,
    S_TAP,
    S_MAC,
    S_DRAIN,
    S_DONE
  } dconv_state_e;

endpackage

FILE: rtl/dconv_ram.sv
module dconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: rtl/dilated_conv1d_forward_core.sv
// Strided, dilated, zero-padded 1D convolution, forward pass, fixed point.
// Input channel: in_valid_i / in_stall_o with operation, index, value,
// out_time and out_channel. Load items (weight, bias, sample) are taken one
// per cycle while the sequencer is idle and write their store; they give
// no result. A compute item gives one result item on the output channel
// (out_valid_o / out_stall_i): conv_value in Q32.16 and status, 1 with a
// zero value when the requested time or channel lies outside the output.
// A compute item passes through setup and the bias read; if the result
// lies inside the output, every tap that lands inside the input then takes
// one multiply-accumulate per cycle per input channel over the weight and
// sample memory ports, padding taps are skipped, and the pipeline drains.
// Only one item is at work at a time; in_stall_o is low while the
// sequencer is idle. Load items are still taken while a result waits.
// When the receiver stalls, the result is held in the output register and
// a following compute item finishes its sums but waits before delivery.
// Reset clears the sequencer and the output register and sets the
// configuration registers to stride 1, no padding, dilation 1 and one tap,
// channel, filter and row. Store contents are undefined until loaded.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i;
// the user must write only while the block is idle; nothing enforces it.
module dilated_conv1d_forward_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [dconv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dconv_pkg::CFG_W-1:0]         cfg_data_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dconv_pkg::OP_W-1:0]          in_operation_i,
  input  logic [dconv_pkg::IDX_W-1:0]         in_index_i,
  input  logic signed [dconv_pkg::VAL_W-1:0]  in_value_i,
  input  logic [dconv_pkg::OT_W-1:0]          in_out_time_i,
  input  logic [dconv_pkg::OC_W-1:0]          in_out_channel_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dconv_pkg::ACC_W-1:0]  out_conv_value_o,
  output logic                                out_status_o
);

  import dconv_pkg::*;

  // configuration registers
  logic [STR_W-1:0]   stride_q;
  logic [PAD_W-1:0]   pad_front_q;
  logic [PAD_W-1:0]   pad_back_q;
  logic [DIL_W-1:0]   dilation_q;
  logic [KLEN_W-1:0]  kernel_len_q;
  logic [INCH_W-1:0]  in_channels_q;
  logic [OUTCH_W-1:0] out_channels_q;
  logic [SLEN_W-1:0]  seq_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q       <= STR_W'(1);
      pad_front_q    <= '0;
      pad_back_q     <= '0;
      dilation_q     <= DIL_W'(1);
      kernel_len_q   <= KLEN_W'(1);
      in_channels_q  <= INCH_W'(1);
      out_channels_q <= OUTCH_W'(1);
      seq_len_q      <= SLEN_W'(1);
    end else if (cfg_we_i) begin
      case (dconv_reg_e'(cfg_index_i))
        REG_STRIDE:       stride_q       <= cfg_data_i[STR_W-1:0];
        REG_PAD_FRONT:    pad_front_q    <= cfg_data_i[PAD_W-1:0];
        REG_PAD_BACK:     pad_back_q     <= cfg_data_i[PAD_W-1:0];
        REG_DILATION:     dilation_q     <= cfg_data_i[DIL_W-1:0];
        REG_KERNEL_LEN:   kernel_len_q   <= cfg_data_i[KLEN_W-1:0];
        REG_IN_CHANNELS:  in_channels_q  <= cfg_data_i[INCH_W-1:0];
        REG_OUT_CHANNELS: out_channels_q <= cfg_data_i[OUTCH_W-1:0];
        REG_SEQ_LEN:      seq_len_q      <= cfg_data_i[SLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // registers clamped into their legal ranges
  logic [STR_W-1:0] st_cl;
  logic [DIL_W-1:0] dl_cl;
  logic [TAP_W-1:0] k_cl;
  logic [CH_W-1:0]  c_cl;
  logic [OCH_W-1:0] o_cl;
  logic [LEN_W-1:0] t_cl;

  always_comb begin
    st_cl = (stride_q == '0) ? STR_W'(1) : ((stride_q > STR_W'(16)) ? STR_W'(16) : stride_q);
    dl_cl = (dilation_q == '0) ? DIL_W'(1) :
            ((dilation_q > DIL_W'(16)) ? DIL_W'(16) : dilation_q);
    k_cl  = (kernel_len_q == '0) ? TAP_W'(1) :
            ((int'(kernel_len_q) > MAX_TAPS) ? TAP_W'(MAX_TAPS) : TAP_W'(kernel_len_q));
    c_cl  = (in_channels_q == '0) ? CH_W'(1) :
            ((int'(in_channels_q) > MAX_IN_CH) ? CH_W'(MAX_IN_CH) : CH_W'(in_channels_q));
    o_cl  = (out_channels_q == '0) ? OCH_W'(1) :
            ((int'(out_channels_q) > MAX_OUT_CH) ? OCH_W'(MAX_OUT_CH) :
             OCH_W'(out_channels_q));
    t_cl  = (seq_len_q == '0) ? LEN_W'(1) :
            ((int'(seq_len_q) > MAX_SEQ) ? LEN_W'(MAX_SEQ) : LEN_W'(seq_len_q));
  end

  // sequencer and datapath registers
  dconv_state_e            state_q, state_d;
  logic [OT_W-1:0]         ot_q, ot_d;
  logic [OC_W-1:0]         oc_q, oc_d;
  logic                    range_q, range_d;
  logic signed [ROW_W-1:0] row_q, row_d;
  logic [OCK_W-1:0]        ock_q, ock_d;
  logic [W_AW-1:0]         wa_q, wa_d;
  logic [S_AW-1:0]         sa_q, sa_d;
  logic [TAP_W-1:0]        k_q, k_d;
  logic [CH_W-1:0]         c_q, c_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                    issue_q;
  logic                    prod_v_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                    out_valid_q, out_valid_d;
  logic signed [ACC_W-1:0] out_conv_q, out_conv_d;
  logic                    out_status_q, out_status_d;

  // memory read data
  logic signed [SMP_W-1:0]  w_rdata;
  logic signed [SMP_W-1:0]  s_rdata;
  logic signed [BIAS_W-1:0] b_rdata;

  // handshake
  logic in_fire;
  logic out_free;
  dconv_op_e in_op;

  assign in_op      = dconv_op_e'(in_operation_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // output range test and starting row
  logic [OTS_W-1:0]  ot_st;
  logic [SPAN_W-1:0] span;
  logic [TOT_W-1:0]  total;
  logic              row_ok;
  logic              last_c;
  logic              k_done;

  always_comb begin
    ot_st  = OTS_W'(ot_q) * OTS_W'(st_cl);
    span   = SPAN_W'(k_cl - TAP_W'(1)) * SPAN_W'(dl_cl) + SPAN_W'(1);
    total  = TOT_W'(t_cl) + TOT_W'(pad_front_q) + TOT_W'(pad_back_q);
    row_ok = !row_q[ROW_W-1] && (row_q < signed'(ROW_W'(t_cl)));
    last_c = (c_q == c_cl - CH_W'(1));
    k_done = (k_q == k_cl);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire && in_op == OP_COMPUTE) state_d = S_SETUP;
      S_SETUP: state_d = S_BIAS;
      S_BIAS:  state_d = range_q ? S_TAP : S_DONE;
      S_TAP: begin
        if (k_done) begin
          state_d = S_DRAIN;
        end else if (row_ok) begin
          state_d = S_MAC;
        end
      end
      S_MAC:   if (last_c) state_d = S_TAP;
      S_DRAIN: if (!issue_q && !prod_v_q) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    ot_d         = ot_q;
    oc_d         = oc_q;
    range_d      = range_q;
    row_d        = row_q;
    ock_d        = ock_q;
    wa_d         = wa_q;
    sa_d         = sa_q;
    k_d          = k_q;
    c_d          = c_q;
    acc_d        = acc_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_conv_d   = out_conv_q;
    out_status_d = out_status_q;

    if (prod_v_q) begin
      acc_d = acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          ot_d = in_out_time_i;
          oc_d = in_out_channel_i;
        end
      end
      S_SETUP: begin
        range_d = (OCH_W'(oc_q) < o_cl) &&
                  ((ROW_W'(ot_st) + ROW_W'(span)) <= ROW_W'(total));
        row_d   = signed'(ROW_W'(ot_st)) - signed'(ROW_W'(pad_front_q));
        ock_d   = OCK_W'(oc_q) * OCK_W'(k_cl);
      end
      S_BIAS: begin
        acc_d = {{(ACC_W-BIAS_W){b_rdata[BIAS_W-1]}}, b_rdata};
        wa_d  = W_AW'(W_AW'(ock_q) * W_AW'(c_cl));
        k_d   = '0;
      end
      S_TAP: begin
        if (!k_done) begin
          if (row_ok) begin
            sa_d = S_AW'(S_AW'(row_q[SEQ_W-1:0]) * S_AW'(c_cl));
            c_d  = '0;
          end else begin
            // tap in the padding: skip its weights
            row_d = row_q + signed'(ROW_W'(dl_cl));
            wa_d  = wa_q + W_AW'(c_cl);
            k_d   = k_q + TAP_W'(1);
          end
        end
      end
      S_MAC: begin
        wa_d = wa_q + W_AW'(1);
        sa_d = sa_q + S_AW'(1);
        c_d  = c_q + CH_W'(1);
        if (last_c) begin
          row_d = row_q + signed'(ROW_W'(dl_cl));
          k_d   = k_q + TAP_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_conv_d   = range_q ? acc_q : '0;
          out_status_d = !range_q;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= 1'b0;
      prod_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= (state_q == S_MAC);
      prod_v_q    <= issue_q;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ot_q         <= ot_d;
    oc_q         <= oc_d;
    range_q      <= range_d;
    row_q        <= row_d;
    ock_q        <= ock_d;
    wa_q         <= wa_d;
    sa_q         <= sa_d;
    k_q          <= k_d;
    c_q          <= c_d;
    acc_q        <= acc_d;
    prod_q       <= s_rdata * w_rdata;
    out_conv_q   <= out_conv_d;
    out_status_q <= out_status_d;
  end

  // store write enables and addresses
  logic            w_we, s_we, b_we;
  logic [W_AW-1:0] w_addr;
  logic [S_AW-1:0] s_addr;
  logic [B_AW-1:0] b_addr;

  always_comb begin
    w_we   = in_fire && (in_op == OP_LOAD_WEIGHT) && (int'(in_index_i) < W_DEPTH);
    s_we   = in_fire && (in_op == OP_LOAD_SAMPLE) && (int'(in_index_i) < S_DEPTH);
    b_we   = in_fire && (in_op == OP_LOAD_BIAS) && (int'(in_index_i) < B_DEPTH);
    w_addr = (state_q == S_MAC) ? wa_q : W_AW'(in_index_i);
    s_addr = (state_q == S_MAC) ? sa_q : S_AW'(in_index_i);
    b_addr = (state_q == S_IDLE) ? B_AW'(in_index_i) : B_AW'(oc_q);
  end

  dconv_ram #(
    .WIDTH (SMP_W),
    .DEPTH (W_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .addr_i  (w_addr),
    .wdata_i (in_value_i[SMP_W-1:0]),
    .rdata_o (w_rdata)
  );

  dconv_ram #(
    .WIDTH (SMP_W),
    .DEPTH (S_DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .addr_i  (s_addr),
    .wdata_i (in_value_i[SMP_W-1:0]),
    .rdata_o (s_rdata)
  );

  dconv_ram #(
    .WIDTH (BIAS_W),
    .DEPTH (B_DEPTH)
  ) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .addr_i  (b_addr),
    .wdata_i (in_value_i[BIAS_W-1:0]),
    .rdata_o (b_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign out_conv_value_o = out_conv_q;
  assign out_status_o     = out_status_q;

  // checks
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && out_stall_i) |=> (state_q == S_DONE))
    else $error("result finished while output register still full");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!issue_q && !prod_v_q))
    else $error("multiply pipeline busy while sequencer idle");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_conv_q == '0))
    else $error("error result carries a nonzero value");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the delivery state");

endmodule
